[sv/trs_pkg.sv]
// ----------------------------------------------------------------------------
// trs_pkg
// Shared types and constants for the top-k record sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package trs_pkg;

  localparam int TOP_COUNT_DEF = 10;
  localparam int QUEUE_DEPTH   = 4;
  localparam int RANK_W        = 4;

  typedef struct packed {
    logic [9:0]  score_key;
    logic [15:0] height_val;
    logic [15:0] weight_val;
    logic [7:0]  gender_code;
    logic [7:0]  division_code;
    logic        batch_end;
  } rec_in_t;

  typedef struct packed {
    logic [9:0]  key;
    logic [15:0] height;
    logic [15:0] weight;
    logic [7:0]  gender;
    logic [7:0]  division;
  } entry_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [9:0]        out_score;
    logic [15:0]       out_height;
    logic [15:0]       out_weight;
    logic [7:0]        out_gender;
    logic [7:0]        out_division;
    logic              final_rank;
  } rec_out_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

[sv/trs_front.sv]
// ----------------------------------------------------------------------------
// trs_front
// Request intake: short queue that decouples the input channel from the
// insertion and emission logic.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_front import trs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    rec_valid,
  output logic    rec_stall,
  input  rec_in_t rec,
  output logic    q_valid,
  output rec_in_t q_rec,
  input  logic    q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rec_in_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign rec_stall = (fill == CNT_W'(QUEUE_DEPTH));
  assign q_valid   = (fill != '0);
  assign q_rec     = mem[rd_ptr];
  assign push      = rec_valid && !rec_stall;
  assign pop       = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/trs_back.sv]
// ----------------------------------------------------------------------------
// trs_back
// Ranked store: parallel compare and shift insertion, then best-first
// emission through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_back import trs_pkg::*; #(
  parameter int TOP_COUNT = TOP_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  rec_in_t  q_rec,
  output logic     q_pop,
  output logic     rank_valid,
  input  logic     rank_stall,
  output rec_out_t ranked
);

  localparam int CNT_W = $clog2(TOP_COUNT + 1);

  entry_t              entries      [TOP_COUNT];
  entry_t              entries_next [TOP_COUNT];
  entry_t              ent_new;
  logic [TOP_COUNT-1:0] ge;
  logic [CNT_W-1:0]    held_count;
  logic [RANK_W-1:0]   rank_cnt;
  back_state_t         state;
  back_state_t         state_next;
  logic                emit_load;
  logic                last_held;
  logic                out_vld;
  rec_out_t            out_reg;

  assign ent_new = '{key:      q_rec.score_key,
                     height:   q_rec.height_val,
                     weight:   q_rec.weight_val,
                     gender:   q_rec.gender_code,
                     division: q_rec.division_code};

  assign last_held = (held_count == CNT_W'(1));

  // held entries that stay ahead of the new record
  always_comb begin
    for (int i = 0; i < TOP_COUNT; i++) begin
      ge[i] = (CNT_W'(i) < held_count) && (entries[i].key >= q_rec.score_key);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (q_pop && q_rec.batch_end) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load && last_held) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    emit_load = 1'b0;
    case (state)
      ST_COLLECT: q_pop     = q_valid;
      ST_EMIT:    emit_load = !out_vld || !rank_stall;
      default: begin
        q_pop     = 1'b0;
        emit_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    entries_next = entries;
    if (q_pop) begin
      if (!ge[0]) begin
        entries_next[0] = ent_new;
      end
      for (int i = 1; i < TOP_COUNT; i++) begin
        if (!ge[i]) begin
          entries_next[i] = ge[i-1] ? ent_new : entries[i-1];
        end
      end
    end else if (emit_load) begin
      for (int i = 0; i < TOP_COUNT - 1; i++) begin
        entries_next[i] = entries[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    entries <= entries_next;
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_reg.rank         <= rank_cnt;
      out_reg.out_score    <= entries[0].key;
      out_reg.out_height   <= entries[0].height;
      out_reg.out_weight   <= entries[0].weight;
      out_reg.out_gender   <= entries[0].gender;
      out_reg.out_division <= entries[0].division;
      out_reg.final_rank   <= last_held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_COLLECT;
      held_count <= '0;
      rank_cnt   <= RANK_W'(1);
      out_vld    <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop && (held_count < CNT_W'(TOP_COUNT))) begin
        held_count <= held_count + 1'b1;
      end else if (emit_load) begin
        held_count <= held_count - 1'b1;
      end
      if (emit_load) begin
        rank_cnt <= last_held ? RANK_W'(1) : rank_cnt + 1'b1;
      end
      if (emit_load) begin
        out_vld <= 1'b1;
      end else if (!rank_stall) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign rank_valid = out_vld;
  assign ranked     = out_reg;

endmodule

`default_nettype wire

[sv/top_k_record_sorter.sv]
// ----------------------------------------------------------------------------
// top_k_record_sorter
// Keeps the best TOP_COUNT records by score key, stable on equal keys, and
// emits them ranked best first on the record marked batch_end.
// ----------------------------------------------------------------------------
//  channel   handshake                payload
//  input     rec_valid / rec_stall    rec    (rec_in_t)
//  output    rank_valid / rank_stall  ranked (rec_out_t)
//
//  one record per cycle is inserted into the ranked store while collecting
//  a batch_end request starts emission of the held records through the
//  single output register; the intake queue keeps taking requests then
//  synchronous reset empties the queue and the store and drops output valid
//  output stall holds the result register and, once the queue fills, rec_stall
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_record_sorter import trs_pkg::*; #(
  parameter int TOP_COUNT = TOP_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     rec_valid,
  output logic     rec_stall,
  input  rec_in_t  rec,
  output logic     rank_valid,
  input  logic     rank_stall,
  output rec_out_t ranked
);

  logic    q_valid;
  logic    q_pop;
  rec_in_t q_rec;

  trs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec       (rec),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .q_pop     (q_pop)
  );

  trs_back #(
    .TOP_COUNT (TOP_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_rec      (q_rec),
    .q_pop      (q_pop),
    .rank_valid (rank_valid),
    .rank_stall (rank_stall),
    .ranked     (ranked)
  );

endmodule

`default_nettype wire

[sv/trs_checker.sv]
// ----------------------------------------------------------------------------
// trs_port_checks
// Port-level checks on the ranked output of the top-k record sorter.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_port_checks import trs_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     rank_valid,
  input logic     rank_stall,
  input rec_out_t ranked
);

  logic              prev_final;
  logic [RANK_W-1:0] prev_rank;
  logic [9:0]        prev_score;
  logic [RANK_W-1:0] rank_exp;
  logic              take;

  assign take     = rank_valid && !rank_stall;
  assign rank_exp = prev_final ? RANK_W'(1) : prev_rank + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_final <= 1'b1;
      prev_rank  <= '0;
      prev_score <= '0;
    end else if (take) begin
      prev_final <= ranked.final_rank;
      prev_rank  <= ranked.rank;
      prev_score <= ranked.out_score;
    end
  end

  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    rank_valid && rank_stall |=> rank_valid)
    else $error("result dropped while stalled");

  a_data_held: assert property (@(posedge clk) disable iff (rst)
    rank_valid && rank_stall |=> $stable(ranked))
    else $error("result changed while stalled");

  a_rank_seq: assert property (@(posedge clk) disable iff (rst)
    take |-> ranked.rank == rank_exp)
    else $error("rank out of sequence");

  a_score_order: assert property (@(posedge clk) disable iff (rst)
    take && !prev_final |-> ranked.out_score <= prev_score)
    else $error("ranked run not in descending key order");

endmodule

bind top_k_record_sorter trs_port_checks u_trs_port_checks (
  .clk        (clk),
  .rst        (rst),
  .rank_valid (rank_valid),
  .rank_stall (rank_stall),
  .ranked     (ranked)
);

`default_nettype wire
